>>> rtl/dofet_pkg.sv
// ----------------------------------------------------------------------------
// dofet_pkg: shared types and constants of the dual optimal filter
// Field widths, arithmetic widths, register indexes and the token that
// travels down the chain of filter cells.
// ----------------------------------------------------------------------------
package dofet_pkg;

  localparam int TAPS       = 4;
  localparam int SMP_W      = 15;
  localparam int BC_W       = 12;
  localparam int FRAC_BITS  = 3;
  localparam int SCL_W      = SMP_W + FRAC_BITS;
  localparam int PARAM_W    = 18;
  localparam int REG_W      = 2 * PARAM_W;
  localparam int DIFF_W     = SCL_W + 2;
  localparam int PROD_W     = DIFF_W + PARAM_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int E_W        = 19;
  localparam int T_W        = 23;
  localparam int E_DROP     = 8;
  localparam int TAU_DROP   = 6;
  localparam int E_SAT      = 131072;
  localparam int T_SAT      = 2097152;
  localparam int SMALL_NEG_E = -80;
  localparam int LARGE_E    = 800;
  // Window factors 8 and 16 are applied as left shifts.
  localparam int NARROW_SHIFT = 3;
  localparam int WIDE_SHIFT   = 4;
  localparam int CMP_W      = 26;
  localparam int FILL_W     = 2;
  localparam int TAP_IDX_W  = $clog2(TAPS);

  localparam int APB_DW     = 64;
  localparam int ADDR_LSB   = 3;
  localparam int IDX_W      = 3;
  localparam int PADDR_W    = IDX_W + ADDR_LSB;

  typedef enum logic [IDX_W-1:0] {
    REG_TAP0,
    REG_TAP1,
    REG_TAP2,
    REG_TAP3,
    REG_PED,
    REG_PRESCALED
  } reg_idx_t;

  typedef struct packed {
    logic signed [PARAM_W-1:0] e;
    logic signed [PARAM_W-1:0] t;
  } coef_pair_t;

  typedef struct packed {
    logic                          valid;
    logic [TAPS-1:0][SCL_W-1:0]    smp;
    logic [BC_W-1:0]               crossing;
    logic signed [ACC_W-1:0]       acc_e;
    logic signed [ACC_W-1:0]       acc_t;
  } tok_t;

  function automatic logic [SCL_W-1:0] scale_sample(input logic [SMP_W-1:0] x,
                                                    input logic prescaled);
    if (prescaled) begin
      return SCL_W'(x);
    end
    return {x, {FRAC_BITS{1'b0}}};
  endfunction

endpackage

>>> rtl/dofet_in_if.sv
// ----------------------------------------------------------------------------
// dofet_in_if: sample channel
// Valid/ready channel carrying one ADC sample with its crossing id.
// ----------------------------------------------------------------------------
interface dofet_in_if;
  logic                        valid;
  logic                        ready;
  logic [dofet_pkg::SMP_W-1:0] adc_sample;
  logic [dofet_pkg::BC_W-1:0]  crossing_id;
  logic                        restart;

  modport source (output valid, output adc_sample, output crossing_id,
                  output restart, input ready);
  modport sink (input valid, input adc_sample, input crossing_id,
                input restart, output ready);
endinterface

>>> rtl/dofet_out_if.sv
// ----------------------------------------------------------------------------
// dofet_out_if: result channel
// Valid/ready channel carrying one filtered energy and tau result.
// ----------------------------------------------------------------------------
interface dofet_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dofet_pkg::E_W-1:0]  energy;
  logic signed [dofet_pkg::T_W-1:0]  tau_energy;
  logic                              tau_pass;
  logic [dofet_pkg::BC_W-1:0]        window_crossing;

  modport source (output valid, output energy, output tau_energy,
                  output tau_pass, output window_crossing, input ready);
  modport sink (input valid, input energy, input tau_energy,
                input tau_pass, input window_crossing, output ready);
endinterface

>>> rtl/dofet_cell.sv
// ----------------------------------------------------------------------------
// dofet_cell: one multiply-accumulate cell of the filter chain
// Takes the head sample of the token, subtracts the pedestals, multiplies by
// the tap coefficients and adds to both running sums.
// ----------------------------------------------------------------------------
module dofet_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  dofet_pkg::tok_t       up,
  input  dofet_pkg::coef_pair_t coef,
  input  dofet_pkg::coef_pair_t ped,
  output dofet_pkg::tok_t       down
);

  logic signed [dofet_pkg::DIFF_W-1:0] diff_e;
  logic signed [dofet_pkg::DIFF_W-1:0] diff_t;
  logic signed [dofet_pkg::DIFF_W-1:0] smp_s;
  logic signed [dofet_pkg::PROD_W-1:0] prod_e;
  logic signed [dofet_pkg::PROD_W-1:0] prod_t;
  dofet_pkg::tok_t                     down_next;

  assign smp_s  = $signed({{(dofet_pkg::DIFF_W - dofet_pkg::SCL_W){1'b0}}, up.smp[0]});
  assign diff_e = smp_s - dofet_pkg::DIFF_W'(ped.e);
  assign diff_t = smp_s - dofet_pkg::DIFF_W'(ped.t);
  assign prod_e = diff_e * coef.e;
  assign prod_t = diff_t * coef.t;

  always_comb begin
    down_next          = up;
    // The consumed sample drops out; the next one moves to the head.
    down_next.smp      = up.smp >> dofet_pkg::SCL_W;
    down_next.acc_e    = up.acc_e + dofet_pkg::ACC_W'(prod_e);
    down_next.acc_t    = up.acc_t + dofet_pkg::ACC_W'(prod_t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down.valid <= 1'b0;
    end else if (load) begin
      down <= down_next;
    end
  end

endmodule

>>> rtl/dofet_out.sv
// ----------------------------------------------------------------------------
// dofet_out: scaling, saturation, tau window and result register
// Drops the fraction bits of both sums, saturates them, derives the tau
// acceptance bit and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module dofet_out (
  input  logic              clk,
  input  logic              rst,
  input  dofet_pkg::tok_t   tok,
  output logic              free,
  dofet_out_if.source       results
);

  logic signed [dofet_pkg::ACC_W-1:0] e_full;
  logic signed [dofet_pkg::ACC_W-1:0] t_full;
  logic signed [dofet_pkg::E_W-1:0]   e_sat;
  logic signed [dofet_pkg::T_W-1:0]   t_sat;
  logic signed [dofet_pkg::CMP_W-1:0] e_c;
  logic signed [dofet_pkg::CMP_W-1:0] e8;
  logic signed [dofet_pkg::CMP_W-1:0] e16;
  logic signed [dofet_pkg::CMP_W-1:0] t_c;
  logic                               pass;

  logic                               valid_q;
  logic signed [dofet_pkg::E_W-1:0]   energy_q;
  logic signed [dofet_pkg::T_W-1:0]   tau_q;
  logic                               pass_q;
  logic [dofet_pkg::BC_W-1:0]         crossing_q;

  assign e_full = tok.acc_e >>> dofet_pkg::E_DROP;
  assign t_full = tok.acc_t >>> dofet_pkg::TAU_DROP;

  always_comb begin
    // Negative energy beyond the limit is forced to zero, not clipped.
    if (e_full > dofet_pkg::E_SAT) begin
      e_sat = dofet_pkg::E_W'(dofet_pkg::E_SAT - 1);
    end else if (e_full < -dofet_pkg::E_SAT) begin
      e_sat = '0;
    end else begin
      e_sat = e_full[dofet_pkg::E_W-1:0];
    end

    if (t_full > dofet_pkg::T_SAT) begin
      t_sat = dofet_pkg::T_W'(dofet_pkg::T_SAT - 1);
    end else if (t_full < -dofet_pkg::T_SAT) begin
      t_sat = dofet_pkg::T_W'(1 - dofet_pkg::T_SAT);
    end else begin
      t_sat = t_full[dofet_pkg::T_W-1:0];
    end

    e_c = dofet_pkg::CMP_W'(e_sat);
    e8  = e_c <<< dofet_pkg::NARROW_SHIFT;
    e16 = e_c <<< dofet_pkg::WIDE_SHIFT;
    t_c = dofet_pkg::CMP_W'(t_sat);

    if (e_sat < 0 && e_sat > dofet_pkg::SMALL_NEG_E) begin
      pass = (t_c > e8) && (t_c < -e8);
    end else if (e_sat < dofet_pkg::LARGE_E) begin
      pass = (t_c > -e8) && (t_c < e8);
    end else begin
      pass = (t_c > -e8) && (t_c < e16);
    end
  end

  assign free = !valid_q || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (free) begin
      valid_q    <= tok.valid;
      energy_q   <= e_sat;
      tau_q      <= t_sat;
      pass_q     <= pass;
      crossing_q <= tok.crossing;
    end
  end

  assign results.valid           = valid_q;
  assign results.energy          = energy_q;
  assign results.tau_energy      = tau_q;
  assign results.tau_pass        = pass_q;
  assign results.window_crossing = crossing_q;

endmodule

>>> rtl/dual_optimal_filter_energy_tau.sv
// ----------------------------------------------------------------------------
// dual_optimal_filter_energy_tau: four-tap energy and tau optimal filter
// Sample history, configuration registers and the chain of filter cells.
// ----------------------------------------------------------------------------
// Usage: samples enter on the valid/ready channel "samples", one per cycle
// while samples.ready is high. The first three samples after a restart only
// fill the window; every later sample yields one result on "results" for the
// window of the last four samples, tagged with the crossing id of the oldest
// one. The first multiply-accumulate cell loads a sample's window token at the
// edge that accepts the sample; the other three cells and the output stage
// each register it in turn. The cell chain sets the sample rate and moves one
// window token per cell each cycle while it is not stalled.
// Stalls: when the receiver holds off, the chain keeps advancing until its
// empty slots are used up; only then does samples.ready fall.
// Reset clears the window fill, the registers and all pending results.
// Configuration is written over the APB port (64-bit data, register i at
// byte address 8*i); the user is to write it only while no result is
// pending, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module dual_optimal_filter_energy_tau (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dofet_pkg::PADDR_W-1:0]   paddr,
  input  logic [dofet_pkg::APB_DW-1:0]    pwdata,
  output logic [dofet_pkg::APB_DW-1:0]    prdata,
  output logic                            pready,
  dofet_in_if.sink                        samples,
  dofet_out_if.source                     results
);

  dofet_pkg::coef_pair_t               taps [dofet_pkg::TAPS];
  dofet_pkg::coef_pair_t               ped;
  logic                                prescaled;

  logic [dofet_pkg::IDX_W-1:0]         cfg_addr;
  dofet_pkg::reg_idx_t                 cfg_idx;
  logic                                cfg_wr;

  logic [dofet_pkg::SMP_W-1:0]         hist_smp [dofet_pkg::TAPS-1];
  logic [dofet_pkg::BC_W-1:0]          hist_bc  [dofet_pkg::TAPS-1];
  logic [dofet_pkg::FILL_W-1:0]        fill_count;
  logic [dofet_pkg::FILL_W-1:0]        fill_count_next;
  logic                                accept;
  logic                                full_now;

  dofet_pkg::tok_t                     stage [dofet_pkg::TAPS+1];
  logic [dofet_pkg::TAPS-1:0]          load;
  logic                                out_free;

  localparam logic [dofet_pkg::FILL_W-1:0] FILL_MAX = dofet_pkg::FILL_W'(dofet_pkg::TAPS - 1);

  // Configuration port.
  assign pready   = 1'b1;
  assign cfg_addr = paddr[dofet_pkg::PADDR_W-1:dofet_pkg::ADDR_LSB];
  assign cfg_idx  = dofet_pkg::reg_idx_t'(cfg_addr);
  assign cfg_wr   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      taps      <= '{default: '0};
      ped       <= '0;
      prescaled <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx) inside
        dofet_pkg::REG_TAP0, dofet_pkg::REG_TAP1,
        dofet_pkg::REG_TAP2, dofet_pkg::REG_TAP3: begin
          taps[cfg_addr[dofet_pkg::TAP_IDX_W-1:0]] <= pwdata[dofet_pkg::REG_W-1:0];
        end
        dofet_pkg::REG_PED: begin
          ped <= pwdata[dofet_pkg::REG_W-1:0];
        end
        dofet_pkg::REG_PRESCALED: begin
          prescaled <= pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx) inside
      dofet_pkg::REG_TAP0, dofet_pkg::REG_TAP1,
      dofet_pkg::REG_TAP2, dofet_pkg::REG_TAP3: begin
        prdata = dofet_pkg::APB_DW'(taps[cfg_addr[dofet_pkg::TAP_IDX_W-1:0]]);
      end
      dofet_pkg::REG_PED: begin
        prdata = dofet_pkg::APB_DW'(ped);
      end
      dofet_pkg::REG_PRESCALED: begin
        prdata = dofet_pkg::APB_DW'(prescaled);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // Window fill and sample history.
  assign accept   = samples.valid && samples.ready;
  assign full_now = !samples.restart && (fill_count == FILL_MAX);

  always_comb begin
    if (samples.restart) begin
      fill_count_next = dofet_pkg::FILL_W'(1);
    end else if (fill_count == FILL_MAX) begin
      fill_count_next = fill_count;
    end else begin
      fill_count_next = fill_count + dofet_pkg::FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= fill_count_next;
    end
  end

  // Once the window is full, the history always holds the last three samples,
  // so a plain shift line serves both the filling and the running case.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < dofet_pkg::TAPS - 2; i++) begin
        hist_smp[i] <= hist_smp[i+1];
        hist_bc[i]  <= hist_bc[i+1];
      end
      hist_smp[dofet_pkg::TAPS-2] <= samples.adc_sample;
      hist_bc[dofet_pkg::TAPS-2]  <= samples.crossing_id;
    end
  end

  // Window token entering the first cell, oldest sample at the head.
  always_comb begin
    stage[0].valid = accept && full_now;
    for (int i = 0; i < dofet_pkg::TAPS - 1; i++) begin
      stage[0].smp[i] = dofet_pkg::scale_sample(hist_smp[i], prescaled);
    end
    stage[0].smp[dofet_pkg::TAPS-1] = dofet_pkg::scale_sample(samples.adc_sample, prescaled);
    stage[0].crossing = hist_bc[0];
    stage[0].acc_e    = '0;
    stage[0].acc_t    = '0;
  end

  // A cell loads when it is empty or its content moves on.
  always_comb begin
    load[dofet_pkg::TAPS-1] = !stage[dofet_pkg::TAPS].valid || out_free;
    for (int k = dofet_pkg::TAPS - 2; k >= 0; k--) begin
      load[k] = !stage[k+1].valid || load[k+1];
    end
  end

  assign samples.ready = load[0];

  for (genvar k = 0; k < dofet_pkg::TAPS; k++) begin : g_cell
    dofet_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .load (load[k]),
      .up   (stage[k]),
      .coef (taps[k]),
      .ped  (ped),
      .down (stage[k+1])
    );
  end

  dofet_out u_out (
    .clk     (clk),
    .rst     (rst),
    .tok     (stage[dofet_pkg::TAPS]),
    .free    (out_free),
    .results (results)
  );

`ifndef ASSERT_OFF
  // An accepted sample starts a window token exactly when the window is full.
  a_token_on_full: assert property (@(posedge clk) disable iff (rst)
    accept |=> (stage[1].valid == $past(full_now)))
    else $error("window token does not match window fill");

  // With every slot occupied and the receiver stalled, no sample may enter.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.ready && stage[1].valid && stage[2].valid &&
     stage[3].valid && stage[4].valid) |-> !samples.ready)
    else $error("sample accepted while the filter chain is full and stalled");

  // A restart leaves exactly one sample in the window.
  a_restart_fill: assert property (@(posedge clk) disable iff (rst)
    (accept && samples.restart) |=> (fill_count == dofet_pkg::FILL_W'(1)))
    else $error("window fill not restarted");
`endif

endmodule
